// ===== hw/rtl/rptm_pkg.sv =====
package rptm_pkg;

   localparam int TABLES_DEF = 64;
   localparam int PAGE_W     = 40;
   localparam int VPN_W      = 36;
   localparam int IDX_W      = 9;
   localparam int LEAF_W     = 52;
   localparam int FLAG_W     = 4;
   localparam int STAT_W     = 2;
   localparam int LEAF_LEVEL = 3;

   localparam logic OP_MAP   = 1'b0;
   localparam logic OP_UNMAP = 1'b1;

   // entry flags: write-through, user, writable, present (msb..lsb)
   localparam logic [FLAG_W-1:0] FLAGS_TABLE = 4'b1111;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK         = 2'd0,
      STAT_MAPPED     = 2'd1,
      STAT_NOT_MAPPED = 2'd2,
      STAT_NO_TABLES  = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      SQ_CLEAR,
      SQ_IDLE,
      SQ_READ,
      SQ_EVAL,
      SQ_ALLOC,
      SQ_SUB,
      SQ_RED,
      SQ_MODW,
      SQ_DONE
   } seq_state_type;

   typedef struct packed {
      logic              op;
      logic [VPN_W-1:0]  virt_page;
      logic [PAGE_W-1:0] phys_page;
      logic              override_existing;
      logic              writable;
      logic              user_perm;
   } req_type;

   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [LEAF_W-1:0] leaf_entry;
   } rsp_type;

   // stored entry: stamp marks whether the owning table was allocated at write time
   typedef struct packed {
      logic              stamp;
      logic [PAGE_W-1:0] page;
      logic [FLAG_W-1:0] flags;
   } ent_type;

endpackage

// ===== hw/rtl/rptm_entry_ram.sv =====
module rptm_entry_ram import rptm_pkg::*; #(
   parameter int TABLES = TABLES_DEF,
   localparam int TBL_W  = $clog2(TABLES),
   localparam int ADDR_W = TBL_W + IDX_W
) (
   input  logic              clock,
   input  logic              mem_we,
   input  logic [ADDR_W-1:0] mem_addr,
   input  ent_type           mem_wdata,
   output ent_type           mem_rdata
);

   localparam int DEPTH = TABLES << IDX_W;

   ent_type mem_array [DEPTH];
   ent_type rdata_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_array[mem_addr] <= mem_wdata;
      end
      rdata_ff <= mem_array[mem_addr];
   end

   assign mem_rdata = rdata_ff;

endmodule

// ===== hw/rtl/rptm_mod_unit.sv =====
module rptm_mod_unit import rptm_pkg::*; #(
   parameter int TABLES = TABLES_DEF,
   localparam int TBL_W = $clog2(TABLES)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              mod_start,
   input  logic [PAGE_W-1:0] mod_value,
   output logic              mod_done,
   output logic [TBL_W-1:0]  mod_result
);

   // restoring remainder, four dividend bits per cycle
   localparam int STEP_W = 4;
   localparam int STEPS  = PAGE_W / STEP_W;
   localparam int CNT_W  = $clog2(STEPS);
   localparam int TRY_W  = TBL_W + STEP_W;

   logic              run_ff, run_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [PAGE_W-1:0] sh_ff, sh_in;
   logic [TBL_W-1:0]  rem_ff, rem_in;
   logic [TRY_W-1:0]  trial;

   // {rem, next four bits} brought below TABLES by conditional subtracts of 8T, 4T, 2T, T
   always_comb begin
      trial = {rem_ff, sh_ff[PAGE_W-1 -: STEP_W]};
      for (int j = STEP_W - 1; j >= 0; j--) begin
         if (trial >= (TRY_W'(TABLES) << j)) begin
            trial = trial - (TRY_W'(TABLES) << j);
         end
      end
   end

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      sh_in   = sh_ff;
      rem_in  = rem_ff;
      if (mod_start) begin
         run_in = 1'b1;
         cnt_in = '0;
         sh_in  = mod_value;
         rem_in = '0;
      end else if (run_ff) begin
         sh_in  = {sh_ff[PAGE_W-STEP_W-1:0], STEP_W'(0)};
         rem_in = trial[TBL_W-1:0];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(STEPS - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      sh_ff  <= sh_in;
      rem_ff <= rem_in;
   end

   assign mod_done   = done_ff;
   assign mod_result = rem_ff;

endmodule

// ===== hw/rtl/rptm_walk_seq.sv =====
module rptm_walk_seq import rptm_pkg::*; #(
   parameter int TABLES = TABLES_DEF,
   localparam int TBL_W  = $clog2(TABLES),
   localparam int CNT_W  = TBL_W + 1,
   localparam int ADDR_W = TBL_W + IDX_W
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  req_type           req_data,
   output logic              rsp_strobe,
   output rsp_type           rsp_data,
   input  logic              csr_we,
   input  logic [PAGE_W-1:0] csr_wdata,
   output logic              mem_we,
   output logic [ADDR_W-1:0] mem_addr,
   output ent_type           mem_wdata,
   input  ent_type           mem_rdata,
   output logic              mod_start,
   output logic [PAGE_W-1:0] mod_value,
   input  logic              mod_done,
   input  logic [TBL_W-1:0]  mod_result
);

   seq_state_type     state_ff, state_in;
   req_type           req_ff, req_in;
   logic [1:0]        lvl_ff, lvl_in;
   logic [TBL_W-1:0]  tbl_ff, tbl_in;
   logic [CNT_W-1:0]  nf_ff, nf_in;
   logic [PAGE_W-1:0] base_ff, base_in;
   logic [PAGE_W-1:0] ptr_ff, ptr_in;
   logic [PAGE_W-1:0] rel_ff, rel_in;
   logic [ADDR_W-1:0] clr_ff, clr_in;
   status_type        stat_ff, stat_in;
   logic [LEAF_W-1:0] leaf_ff, leaf_in;

   logic [IDX_W-1:0]  idx;
   logic              alloc;
   logic              present;
   logic              at_leaf;
   logic              pool_full;
   logic              fits;
   logic [FLAG_W-1:0] leaf_flags;

   always_comb begin
      case (lvl_ff)
         2'd0:    idx = req_ff.virt_page[35:27];
         2'd1:    idx = req_ff.virt_page[26:18];
         2'd2:    idx = req_ff.virt_page[17:9];
         default: idx = req_ff.virt_page[8:0];
      endcase
   end

   // a table counts as allocated once the bump counter has passed it
   assign alloc      = {1'b0, tbl_ff} < nf_ff;
   assign present    = (mem_rdata.stamp == alloc) &&
                       ((mem_rdata.page != '0) || (mem_rdata.flags != '0));
   assign at_leaf    = lvl_ff == 2'(LEAF_LEVEL);
   assign pool_full  = nf_ff >= CNT_W'(TABLES);
   assign fits       = (rel_ff[PAGE_W-1:TBL_W] == '0) &&
                       ({1'b0, rel_ff[TBL_W-1:0]} < CNT_W'(TABLES));
   assign leaf_flags = {1'b1, req_ff.user_perm, req_ff.writable, 1'b1};

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         SQ_CLEAR: if (clr_ff == '1) state_in = SQ_IDLE;
         SQ_IDLE:  if (start) state_in = SQ_READ;
         SQ_READ:  state_in = SQ_EVAL;
         SQ_EVAL: begin
            if (at_leaf) begin
               state_in = SQ_DONE;
            end else if (present) begin
               state_in = SQ_SUB;
            end else if (req_ff.op == OP_UNMAP || pool_full) begin
               state_in = SQ_DONE;
            end else begin
               state_in = SQ_ALLOC;
            end
         end
         SQ_ALLOC: state_in = SQ_SUB;
         SQ_SUB:   state_in = SQ_RED;
         SQ_RED:   state_in = fits ? SQ_READ : SQ_MODW;
         SQ_MODW:  if (mod_done) state_in = SQ_READ;
         SQ_DONE:  state_in = SQ_IDLE;
         default:  state_in = SQ_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      req_in    = req_ff;
      lvl_in    = lvl_ff;
      tbl_in    = tbl_ff;
      nf_in     = nf_ff;
      ptr_in    = ptr_ff;
      rel_in    = rel_ff;
      clr_in    = clr_ff;
      stat_in   = stat_ff;
      leaf_in   = leaf_ff;
      base_in   = csr_we ? csr_wdata : base_ff;
      mem_we    = 1'b0;
      mem_addr  = {tbl_ff, idx};
      mem_wdata = '{stamp: alloc, page: '0, flags: '0};
      mod_start = 1'b0;
      unique case (state_ff)
         SQ_CLEAR: begin
            mem_we    = 1'b1;
            mem_addr  = clr_ff;
            mem_wdata = '0;
            clr_in    = clr_ff + 1'b1;
         end
         SQ_IDLE: begin
            if (start) begin
               req_in  = req_data;
               lvl_in  = '0;
               tbl_in  = '0;
               stat_in = STAT_OK;
               leaf_in = '0;
            end
         end
         SQ_READ: ;
         SQ_EVAL: begin
            if (!at_leaf) begin
               if (present) begin
                  ptr_in = mem_rdata.page;
               end else if (req_ff.op == OP_UNMAP) begin
                  stat_in = STAT_NOT_MAPPED;
               end else if (pool_full) begin
                  stat_in = STAT_NO_TABLES;
               end else begin
                  ptr_in = base_ff + PAGE_W'(nf_ff);
                  nf_in  = nf_ff + 1'b1;
               end
            end else if (req_ff.op == OP_UNMAP) begin
               if (!present) begin
                  stat_in = STAT_NOT_MAPPED;
               end else begin
                  mem_we = 1'b1;
               end
            end else if (!req_ff.override_existing && present) begin
               stat_in = STAT_MAPPED;
            end else begin
               mem_we    = 1'b1;
               mem_wdata = '{stamp: alloc, page: req_ff.phys_page, flags: leaf_flags};
               leaf_in   = {req_ff.phys_page, 8'h00, leaf_flags};
            end
         end
         SQ_ALLOC: begin
            // counter already bumped, so a stale pointer into the new table stamps valid
            mem_we    = 1'b1;
            mem_wdata = '{stamp: alloc, page: ptr_ff, flags: FLAGS_TABLE};
         end
         SQ_SUB: rel_in = ptr_ff - base_ff;
         SQ_RED: begin
            if (fits) begin
               tbl_in = rel_ff[TBL_W-1:0];
               lvl_in = lvl_ff + 1'b1;
            end else begin
               mod_start = 1'b1;
            end
         end
         SQ_MODW: begin
            if (mod_done) begin
               tbl_in = mod_result;
               lvl_in = lvl_ff + 1'b1;
            end
         end
         SQ_DONE: ;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SQ_CLEAR;
         clr_ff   <= '0;
         nf_ff    <= CNT_W'(1);
         base_ff  <= '0;
         lvl_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         nf_ff    <= nf_in;
         base_ff  <= base_in;
         lvl_ff   <= lvl_in;
      end
      req_ff  <= req_in;
      tbl_ff  <= tbl_in;
      ptr_ff  <= ptr_in;
      rel_ff  <= rel_in;
      stat_ff <= stat_in;
      leaf_ff <= leaf_in;
   end

   assign busy       = state_ff != SQ_IDLE;
   assign rsp_strobe = state_ff == SQ_DONE;
   assign rsp_data   = '{status: stat_ff, leaf_entry: leaf_ff};
   assign mod_value  = rel_ff;

endmodule

// ===== hw/rtl/radix_page_table_mapper_unit.sv =====
// Channel   | Ports                          | Beat taken when
// ----------+--------------------------------+----------------------------------
// request   | start, busy, req_data          | start & !busy at rising edge
// response  | rsp_strobe, rsp_data           | every cycle rsp_strobe is high
// csr       | csr_we, csr_wdata              | csr_we at rising edge (pool base)
//
// Steps: each walk level passes through read, evaluate, subtract and reduce, plus an
//   allocate write when a table is allocated; the leaf passes through read, evaluate, done.
//   The next beat can be taken once the sequencer is back in idle after the strobe; the
//   chain of dependent reads on the one entry RAM port sets the pace.
// A table pointer that lands outside the pool range goes through the remainder unit
//   for that level.
// Reset: a clearing pass writes all TABLES*512 entries, one per cycle, with busy high.
// The response cannot be stalled; it is shown for one cycle only.
module radix_page_table_mapper_unit import rptm_pkg::*; #(
   parameter int TABLES = TABLES_DEF,
   localparam int TBL_W  = $clog2(TABLES),
   localparam int ADDR_W = TBL_W + IDX_W
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  req_type           req_data,
   output logic              rsp_strobe,
   output rsp_type           rsp_data,
   input  logic              csr_we,
   input  logic [PAGE_W-1:0] csr_wdata
);

   // entry RAM port
   logic              mem_we;
   logic [ADDR_W-1:0] mem_addr;
   ent_type           mem_wdata;
   ent_type           mem_rdata;

   // remainder unit for stale pointers
   logic              mod_start;
   logic [PAGE_W-1:0] mod_value;
   logic              mod_done;
   logic [TBL_W-1:0]  mod_result;

   // walk sequencer: owns the bump counter, pool base and the request beat
   rptm_walk_seq #(
      .TABLES (TABLES)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .mem_we     (mem_we),
      .mem_addr   (mem_addr),
      .mem_wdata  (mem_wdata),
      .mem_rdata  (mem_rdata),
      .mod_start  (mod_start),
      .mod_value  (mod_value),
      .mod_done   (mod_done),
      .mod_result (mod_result)
   );

   // pool of tables, {table, index} addressed, registered read
   rptm_entry_ram #(
      .TABLES (TABLES)
   ) u_ram (
      .clock     (clock),
      .mem_we    (mem_we),
      .mem_addr  (mem_addr),
      .mem_wdata (mem_wdata),
      .mem_rdata (mem_rdata)
   );

   rptm_mod_unit #(
      .TABLES (TABLES)
   ) u_mod (
      .clock      (clock),
      .reset      (reset),
      .mod_start  (mod_start),
      .mod_value  (mod_value),
      .mod_done   (mod_done),
      .mod_result (mod_result)
   );

endmodule

// ===== hw/rtl/rptm_checker.sv =====
module rptm_checker import rptm_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input logic    rsp_strobe,
   input rsp_type rsp_data
);

   // response only while a request is in flight
   a_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> busy)
      else $error("response beat while idle");

   // accepted beat starts a walk
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy && !rsp_strobe))
      else $error("accept not followed by walk");

   // one beat per response
   a_single_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> (!rsp_strobe && !busy))
      else $error("response held past one cycle");

   // failures carry no leaf
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.status != STAT_OK) |-> (rsp_data.leaf_entry == '0))
      else $error("leaf value on failed request");

   // a written leaf is present and write-through
   a_leaf_flags: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.leaf_entry != '0) |->
         (rsp_data.leaf_entry[0] && rsp_data.leaf_entry[3]))
      else $error("leaf missing present or write-through");

endmodule

bind radix_page_table_mapper_unit rptm_checker u_rptm_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_strobe (rsp_strobe),
   .rsp_data   (rsp_data)
);
